// ===== rtl/nps_pkg.sv =====
package nps_pkg;

  localparam int IDX_W  = 8;
  localparam int CHAN_W = 8;
  localparam int COLOR_W = 4 * CHAN_W;
  localparam int DIST_W = 18;

  // Only the upper seven bits of every channel take part in the distance.
  localparam logic [CHAN_W-1:0] CHAN_MASK = 8'hfe;

  // Larger than any reachable distance, so the first cell always takes the lead.
  localparam logic [DIST_W-1:0] DIST_INIT = '1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  match_index;
    logic [DIST_W-1:0] match_distance;
  } out_item_t;

  // One slot of the cell chain. The colour is packed red in the low byte.
  typedef struct packed {
    logic               vld;
    logic               req_type;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   best_idx;
    logic [DIST_W-1:0]  best_dist;
  } link_t;

endpackage

// ===== rtl/nps_cell.sv =====
module nps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  nps_pkg::link_t link_i,
  output nps_pkg::link_t link_o
);
  import nps_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [COLOR_W-1:0] entry_r;
  link_t              link_r;
  link_t              link_nxt;
  logic [DIST_W-1:0]  cand_dist;
  logic [15:0]        sum;
  logic [CHAN_W-1:0]  a_ch;
  logic [CHAN_W-1:0]  b_ch;
  logic [CHAN_W-1:0]  diff;
  logic [6:0]         d7;
  logic [13:0]        sq;

  // Masked channels have bit 0 clear, so the difference is a 7-bit value
  // shifted left by one and its square is four times the 7-bit square.
  always_comb begin
    sum  = '0;
    a_ch = '0;
    b_ch = '0;
    diff = '0;
    d7   = '0;
    sq   = '0;
    for (int c = 0; c < 4; c++) begin
      a_ch = link_i.color[c*CHAN_W +: CHAN_W] & CHAN_MASK;
      b_ch = entry_r[c*CHAN_W +: CHAN_W] & CHAN_MASK;
      diff = (a_ch > b_ch) ? (a_ch - b_ch) : (b_ch - a_ch);
      d7   = diff[7:1];
      sq   = 14'(d7) * 14'(d7);
      sum  = sum + 16'(sq);
    end
    cand_dist = {sum, 2'b00};
  end

  always_comb begin
    link_nxt = link_i;
    if (link_i.vld && (link_i.req_type == REQ_QUERY) &&
        (cand_dist < link_i.best_dist)) begin
      link_nxt.best_idx  = MY_IDX;
      link_nxt.best_dist = cand_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.vld <= 1'b0;
    end else if (adv) begin
      link_r <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else if (adv && link_i.vld && (link_i.req_type == REQ_WRITE) &&
                 (link_i.entry_index == MY_IDX)) begin
      entry_r <= link_i.color;
    end
  end

  assign link_o = link_r;

endmodule

// ===== rtl/nearest_palette_color_search.sv =====
// Nearest palette color search. The block holds PALETTE_ENTRIES RGBA
// entries, all zero after reset. A write transaction stores one entry and
// gives no result; a write to a slot at or above PALETTE_ENTRIES is dropped.
// A query transaction returns the lowest index whose color has the smallest
// sum of squared channel differences, with every channel of both colors
// masked to its upper seven bits, together with that distance. The palette
// lives in a chain of PALETTE_ENTRIES identical cells, one entry per cell.
// Every transaction walks the chain one cell per cycle while the chain is
// not stalled: a write is captured by the cell that owns its slot, and a
// query picks up the best entry seen so far. Because transactions never
// overtake each other in the chain, each query sees exactly the writes that
// were accepted before it. The block accepts one transaction per cycle while
// not stalled; a query's result is registered by every cell in turn and then
// by the output register. A stall on the result side freezes the whole
// chain, and in_stall is raised in the same cycle.
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  nps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output nps_pkg::out_item_t out_data
);
  import nps_pkg::*;

  // Slot k feeds cell k; the last slot feeds the output register.
  link_t     chain [0:PALETTE_ENTRIES];
  logic      adv;
  logic      out_valid_r;
  out_item_t out_data_r;

  // The chain moves whenever the output register is free or being emptied.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // The incoming transaction enters with a best distance that every real
  // distance beats, so the first cell always claims the lead.
  always_comb begin
    chain[0].vld         = in_valid;
    chain[0].req_type    = in_data.req_type;
    chain[0].entry_index = in_data.entry_index;
    chain[0].color       = {in_data.alpha, in_data.blue, in_data.green, in_data.red};
    chain[0].best_idx    = '0;
    chain[0].best_dist   = DIST_INIT;
  end

  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    nps_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .link_i (chain[k]),
      .link_o (chain[k+1])
    );
  end

  // Writes leave the chain silently; only queries produce a transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[PALETTE_ENTRIES].vld &&
                     (chain[PALETTE_ENTRIES].req_type == REQ_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.match_index    <= chain[PALETTE_ENTRIES].best_idx;
      out_data_r.match_distance <= chain[PALETTE_ENTRIES].best_dist;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/nps_checker.sv =====
module nps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input nps_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input nps_pkg::out_item_t out_data
);
  import nps_pkg::*;

  localparam logic [DIST_W-1:0] DIST_MAX = 18'd258064;

  // The input side is held back only by a result that is waiting.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the output register");

  // Masked channels keep every distance within four squared 254 steps.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.match_distance <= DIST_MAX))
    else $error("match_distance out of range");

  // Nothing reaches the output in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result transaction right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result transaction dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result payload changed");

endmodule

bind nearest_palette_color_search nps_checker u_nps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
